>>> hw/rtl/fzr_pkg.sv
package fzr_pkg;

  localparam int MaxWidthDefault  = 256;
  localparam int MaxHeightDefault = 256;
  localparam int ValueBitsDefault = 32;
  localparam int CfgIndexBits     = 2;
  localparam int CfgDataBits      = 9;

  localparam logic [CfgIndexBits-1:0] CfgConnectivity = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgImageWidth   = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgImageHeight  = 2'd2;

  localparam logic [1:0] MarkNone = 2'd0;
  localparam logic [1:0] MarkOrig = 2'd1;
  localparam logic [1:0] MarkDone = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StNormRd,
    StNormWr,
    StScanRd,
    StScanChk,
    StPopRd,
    StPopWait,
    StNbrRd,
    StNbrChk,
    StRdWait,
    StRdOut
  } state_t;

endpackage

>>> hw/rtl/fzr_stream_if.sv
interface fzr_stream_if #(
  parameter int Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fzr_ram.sv
module fzr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fzr_nbr.sv
module fzr_nbr #(
  parameter int XBits = 8,
  parameter int YBits = 8
) (
  input  logic [2:0]       k,
  input  logic [XBits-1:0] col,
  input  logic [YBits-1:0] row,
  input  logic [XBits:0]   w,
  input  logic [YBits:0]   h,
  output logic             ok,
  output logic [XBits-1:0] ncol,
  output logic [YBits-1:0] nrow
);

  logic e, wst, n, s;

  always_comb begin
    e = ({1'b0, col} + 1'b1) < w;
    wst = col != '0;
    n = row != '0;
    s = ({1'b0, row} + 1'b1) < h;
    ncol = col;
    nrow = row;
    ok = 1'b0;
    case (k)
      3'd0: begin ok = e; ncol = col + 1'b1; end
      3'd1: begin ok = e && n; ncol = col + 1'b1; nrow = row - 1'b1; end
      3'd2: begin ok = n; nrow = row - 1'b1; end
      3'd3: begin ok = wst && n; ncol = col - 1'b1; nrow = row - 1'b1; end
      3'd4: begin ok = wst; ncol = col - 1'b1; end
      3'd5: begin ok = wst && s; ncol = col - 1'b1; nrow = row + 1'b1; end
      3'd6: begin ok = s; nrow = row + 1'b1; end
      default: begin ok = e && s; ncol = col + 1'b1; nrow = row + 1'b1; end
    endcase
  end

endmodule

>>> hw/rtl/flat_zone_reconstruction.sv
// Channel  Dir  Payload
// in       in   command, pixel_value, marker, last_pixel
// out      out  result_value, result_last
// cfg      in   cfg_we, cfg_index, cfg_data
// A load is written to the stores as it is accepted; a read passes StRdWait and StRdOut
// and then waits on the result handshake. The fill after the last pixel normalizes and
// scans the marks pixel by pixel; each popped pixel passes StPopRd and StPopWait, and
// each in-image neighbor StNbrRd and StNbrChk (a skipped one StNbrRd only).
// Reset is synchronous; memories are not cleared and read as written.
// A stalled result holds the block until it is taken.
module flat_zone_reconstruction #(
  parameter int MaxWidth  = fzr_pkg::MaxWidthDefault,
  parameter int MaxHeight = fzr_pkg::MaxHeightDefault,
  parameter int ValueBits = fzr_pkg::ValueBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fzr_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [fzr_pkg::CfgDataBits-1:0]  cfg_data,
  fzr_stream_if.sink                      in,
  fzr_stream_if.source                    out
);

  localparam int XBits = $clog2(MaxWidth);
  localparam int YBits = $clog2(MaxHeight);
  localparam int ABits = XBits + YBits;
  localparam int Depth = 1 << ABits;
  localparam int MarkerBit = 33;
  localparam int LastBit   = 34;

  fzr_pkg::state_t state, state_next;

  logic             connectivity;
  logic [8:0]       image_width, image_height;
  logic [XBits:0]   w;
  logic [YBits:0]   h;
  logic [XBits-1:0] col, zcol, ncol;
  logic [YBits-1:0] row, zrow, nrow;
  logic [ABits:0]   sp;
  logic [2:0]       k;
  logic             nbr_ok, col_last, row_last;
  logic [ValueBits-1:0] seed_val;
  logic [31:0]      res_value;
  logic             res_last, out_valid;
  logic [ABits:0]   npix, load_index, read_index, rd_idx, rd_next;
  logic [YBits-1:0] arow;
  logic [XBits-1:0] acol;
  logic [ABits:0]   addr_full;
  logic [ABits-1:0] faddr;

  logic             vwe, mwe, swe;
  logic [ABits-1:0] vwa, vra, mwa, mra, swa, sra;
  logic [ValueBits-1:0] vwd, vrd;
  logic [1:0]       mwd, mrd;
  logic [ABits-1:0] swd, srd;

  always_comb begin
    if (image_width == 9'd0) w = (XBits+1)'(1);
    else if ({23'd0, image_width} > 32'(MaxWidth)) w = (XBits+1)'(MaxWidth);
    else w = (XBits+1)'(image_width);
    if (image_height == 9'd0) h = (YBits+1)'(1);
    else if ({23'd0, image_height} > 32'(MaxHeight)) h = (YBits+1)'(MaxHeight);
    else h = (YBits+1)'(image_height);
  end

  assign col_last = ({1'b0, col} + 1'b1) >= w;
  assign row_last = ({1'b0, row} + 1'b1) >= h;

  assign npix = {{YBits{1'b0}}, w} * {{XBits{1'b0}}, h};
  assign rd_idx = (read_index >= npix) ? '0 : read_index;
  assign rd_next = rd_idx + 1'b1;

  fzr_ram #(.Width(ValueBits), .Depth(Depth)) u_value (
    .clk, .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(vra), .rdata(vrd));
  fzr_ram #(.Width(2), .Depth(Depth)) u_mark (
    .clk, .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd));
  fzr_ram #(.Width(ABits), .Depth(Depth)) u_stack (
    .clk, .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd));

  fzr_nbr #(.XBits(XBits), .YBits(YBits)) u_nbr (
    .k, .col(zcol), .row(zrow), .w, .h, .ok(nbr_ok), .ncol, .nrow);

  logic is_load, acc;
  assign acc = in.valid && in.ready;
  assign is_load = !in.data[0];

  always_comb begin
    state_next = state;
    case (state)
      fzr_pkg::StIdle:
        if (acc) begin
          if (!is_load) state_next = fzr_pkg::StRdWait;
          else if (in.data[LastBit]) state_next = fzr_pkg::StNormRd;
        end
      fzr_pkg::StNormRd: state_next = fzr_pkg::StNormWr;
      fzr_pkg::StNormWr:
        state_next = (col_last && row_last) ? fzr_pkg::StScanRd : fzr_pkg::StNormRd;
      fzr_pkg::StScanRd: state_next = fzr_pkg::StScanChk;
      fzr_pkg::StScanChk:
        if (mrd == fzr_pkg::MarkOrig) state_next = fzr_pkg::StPopRd;
        else if (col_last && row_last) state_next = fzr_pkg::StIdle;
        else state_next = fzr_pkg::StScanRd;
      fzr_pkg::StPopRd:
        if (sp == '0) state_next = (col_last && row_last) ? fzr_pkg::StIdle : fzr_pkg::StScanRd;
        else state_next = fzr_pkg::StPopWait;
      fzr_pkg::StPopWait: state_next = fzr_pkg::StNbrRd;
      fzr_pkg::StNbrRd: state_next = nbr_ok ? fzr_pkg::StNbrChk : fzr_pkg::StNbrRd;
      fzr_pkg::StNbrChk: state_next = fzr_pkg::StNbrRd;
      fzr_pkg::StRdWait: state_next = fzr_pkg::StRdOut;
      fzr_pkg::StRdOut: if (out.ready) state_next = fzr_pkg::StIdle;
      default: state_next = fzr_pkg::StIdle;
    endcase
    if ((state == fzr_pkg::StNbrRd && !nbr_ok) || state == fzr_pkg::StNbrChk) begin
      if (k > 3'd7 - (connectivity ? 3'd1 : 3'd2)) state_next = fzr_pkg::StPopRd;
    end
  end

  // Store addresses are linear, row*w + col, as in raster order.
  always_comb begin
    arow = row;
    acol = col;
    if (state inside {fzr_pkg::StNbrRd, fzr_pkg::StNbrChk}) begin
      arow = nrow;
      acol = ncol;
    end
    addr_full = {{(XBits+1){1'b0}}, arow} * {{YBits{1'b0}}, w} + {{(YBits+1){1'b0}}, acol};
  end

  assign faddr = addr_full[ABits-1:0];

  always_comb begin
    vwe = 1'b0; mwe = 1'b0; swe = 1'b0;
    vwa = load_index[ABits-1:0]; vwd = in.data[ValueBits:1];
    vra = faddr; mwa = faddr; mra = faddr;
    mwd = in.data[MarkerBit] ? fzr_pkg::MarkOrig : fzr_pkg::MarkNone;
    swa = sp[ABits-1:0]; swd = {row, col}; sra = sp[ABits-1:0] - 1'b1;
    in.ready = state == fzr_pkg::StIdle;
    case (state)
      fzr_pkg::StIdle: begin
        vwe = acc && is_load && (load_index < npix);
        mwe = vwe;
        mwa = load_index[ABits-1:0];
        vra = rd_idx[ABits-1:0];
        mra = rd_idx[ABits-1:0];
      end
      fzr_pkg::StNormWr: begin
        mwe = mrd != fzr_pkg::MarkNone;
        mwd = fzr_pkg::MarkOrig;
      end
      fzr_pkg::StScanChk: begin
        mwe = mrd == fzr_pkg::MarkOrig;
        mwd = fzr_pkg::MarkDone;
        swe = mwe;
      end
      fzr_pkg::StNbrChk: begin
        swd = {nrow, ncol};
        mwe = vrd == seed_val && mrd != fzr_pkg::MarkDone;
        mwd = fzr_pkg::MarkDone;
        swe = mwe;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fzr_pkg::StIdle;
      connectivity <= 1'b0;
      image_width <= 9'd256;
      image_height <= 9'd256;
      col <= '0; row <= '0;
      load_index <= '0; read_index <= '0; sp <= '0; k <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          fzr_pkg::CfgConnectivity: connectivity <= cfg_data[0];
          fzr_pkg::CfgImageWidth: image_width <= cfg_data;
          fzr_pkg::CfgImageHeight: image_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        fzr_pkg::StIdle: begin
          if (acc && is_load) begin
            if (in.data[LastBit]) begin
              col <= '0; row <= '0;
            end
            if (load_index < npix) load_index <= load_index + 1'b1;
          end
        end
        fzr_pkg::StNormWr, fzr_pkg::StPopRd: begin
          if ((state == fzr_pkg::StNormWr || sp == '0) && !(col_last && row_last)) begin
            if (col_last) begin col <= '0; row <= row + 1'b1; end
            else col <= col + 1'b1;
          end else if (state == fzr_pkg::StNormWr || sp == '0) begin
            col <= '0; row <= '0;
            if (state == fzr_pkg::StPopRd) begin
              load_index <= '0; read_index <= '0;
            end
          end
          if (state == fzr_pkg::StPopRd && sp != '0) sp <= sp - 1'b1;
        end
        fzr_pkg::StScanChk: begin
          if (mrd == fzr_pkg::MarkOrig) begin
            seed_val <= vrd;
            sp <= sp + 1'b1;
          end else if (!(col_last && row_last)) begin
            if (col_last) begin col <= '0; row <= row + 1'b1; end
            else col <= col + 1'b1;
          end else begin
            col <= '0; row <= '0; load_index <= '0; read_index <= '0;
          end
        end
        fzr_pkg::StPopWait: begin
          zcol <= srd[XBits-1:0];
          zrow <= srd[ABits-1:XBits];
          k <= '0;
        end
        fzr_pkg::StNbrRd: if (!nbr_ok) k <= k + (connectivity ? 3'd1 : 3'd2);
        fzr_pkg::StNbrChk: begin
          k <= k + (connectivity ? 3'd1 : 3'd2);
          if (vrd == seed_val && mrd != fzr_pkg::MarkDone) sp <= sp + 1'b1;
        end
        fzr_pkg::StRdWait: begin
          res_value <= 32'(mrd == fzr_pkg::MarkDone ? vrd : '0);
          res_last <= rd_next == npix;
          out_valid <= 1'b1;
          read_index <= (rd_next == npix) ? '0 : rd_next;
        end
        fzr_pkg::StRdOut: if (out.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out.valid = out_valid;
  assign out.data = {res_last, res_value};

  assert property (@(posedge clk) disable iff (rst) out.valid |-> state == fzr_pkg::StRdOut)
    else $error("result shown outside read-out");
  assert property (@(posedge clk) disable iff (rst) in.ready |-> !out.valid)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst)
    state == fzr_pkg::StNbrChk |=> sp >= $past(sp))
    else $error("stack shrank during a neighbor check");

endmodule
